// File: design/ffa_pkg.sv
package ffa_pkg;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOFIT  = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	localparam logic [0:0] REQ_ALLOC = 1'b0;
	localparam logic [0:0] REQ_FREE  = 1'b1;

	localparam logic [31:0] PAGE_ADD  = 32'h0000_0fff;
	localparam logic [31:0] PAGE_MASK = 32'hffff_f000;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_PREV_RD,
		S_FREE_DEC,
		S_SHL_RD,
		S_SHL_WR,
		S_SHR_RD,
		S_SHR_WR,
		S_WRITE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] alloc_addr;
		logic [1:0]  status;
		logic [8:0]  entries_used;
		logic [8:0]  entries_peak;
		logic [31:0] total_free_bytes;
		logic [31:0] fail_count;
		logic [31:0] lost_bytes;
	} result_t;

endpackage

// File: design/ffa_ram.sv
module ffa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: design/ffa_out_reg.sv
module ffa_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  ffa_pkg::result_t  res,
	output logic              busy,
	output logic              tvalid,
	input  logic              tready,
	output ffa_pkg::result_t  tdata_res
);
	import ffa_pkg::*;

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tdata_res <= res;
		end
	end

	assign tvalid = valid_q;
	assign busy   = valid_q && !tready;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !busy) else $error("result overwritten");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !tready && !load) |=> valid_q) else $error("result lost");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && tready && !load) |=> !valid_q) else $error("result repeated");
endmodule

// File: design/first_fit_free_list_allocator.sv
// first-fit free region allocator with coalescing
// input channel s_axis: one request item per handshake, tdata holds
// req_type, req_addr, req_size, round_to_page from the lowest bit up.
// output channel m_axis: one result item per request.
// the region table (start, length) sits in one single-port-write ram of
// TABLE_DEPTH entries with a registered read, kept sorted by start.
// an allocate scans entries, a read and a check state per entry, until the
// first fit, and removing an emptied region shifts the tail down, a read
// and a write state per entry. a free scans for its place, then merges,
// shifts the tail up to insert, a read and a write state per moved entry,
// or, when it cannot merge and the table is full, drops the freed region.
// the next item can be taken in the cycle after the result is loaded. one
// request is in work at a time.
// the result sits in an output register; while it waits for m_axis_tready the
// block finishes the next request but holds it until the register is free.
// reset clears counters and totals; the table needs no clearing since only
// entries below the region count are read.
module first_fit_free_list_allocator #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// req_type[0], req_addr[32:1], req_size[64:33], round_to_page[65], zero pad
	input  logic [71:0]   s_axis_tdata,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// alloc_addr[31:0], status[33:32], entries_used[42:34], entries_peak[51:43],
	// total_free_bytes[83:52], fail_count[115:84], lost_bytes[147:116], zero pad
	output logic [151:0]  m_axis_tdata
);
	import ffa_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t state_q, state_d;

	logic          type_q;
	logic [31:0]   addr_q, size_q;
	logic [CW-1:0] idx_q, cnt_q, peak_q, j_q;
	logic [31:0]   total_q, dcnt_q, dbytes_q, res_addr_q;
	logic [1:0]    status_q;
	logic [31:0]   cur_start_q, cur_len_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [63:0]   wdata, rdata;

	ffa_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic [31:0] rd_start, rd_len;
	assign rd_start = rdata[31:0];
	assign rd_len   = rdata[63:32];

	logic        busy, load;
	result_t     res, res_out;

	ffa_out_reg u_out (
		.clk(clk), .arst_n(arst_n), .load(load), .res(res), .busy(busy),
		.tvalid(m_axis_tvalid), .tready(m_axis_tready), .tdata_res(res_out)
	);

	assign m_axis_tdata = {4'd0, res_out.lost_bytes, res_out.fail_count,
		res_out.total_free_bytes, res_out.entries_peak, res_out.entries_used,
		res_out.status, res_out.alloc_addr};

	assign s_axis_tready = (state_q == S_IDLE);

	logic [31:0] in_size;
	assign in_size = s_axis_tdata[65] ? ((s_axis_tdata[64:33] + PAGE_ADD) & PAGE_MASK)
		: s_axis_tdata[64:33];

	logic        at_end, prev_adj, next_adj;
	assign at_end   = (idx_q == cnt_q);
	assign prev_adj = (idx_q != '0) && (rd_start + rd_len == addr_q);
	assign next_adj = !at_end && (addr_q + size_q == cur_start_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (s_axis_tvalid) state_d = S_SCAN_RD;
			S_SCAN_RD: state_d = (idx_q == cnt_q) ?
				((type_q == REQ_ALLOC) ? S_DONE : S_PREV_RD) : S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (type_q == REQ_ALLOC) begin
					if (rd_len >= size_q) state_d = (rd_len == size_q) ? S_SHL_RD : S_DONE;
					else state_d = S_SCAN_RD;
				end else begin
					state_d = (rd_start > addr_q) ? S_PREV_RD : S_SCAN_RD;
				end
			end
			S_PREV_RD: state_d = S_FREE_DEC;
			S_FREE_DEC: begin
				if (prev_adj) state_d = next_adj ? S_SHL_RD : S_DONE;
				else if (next_adj) state_d = S_DONE;
				else if (cnt_q < CW'(TABLE_DEPTH)) state_d = S_SHR_RD;
				else state_d = S_DONE;
			end
			S_SHL_RD: state_d = (j_q + 1'b1 >= cnt_q) ? S_DONE : S_SHL_WR;
			S_SHL_WR: state_d = S_SHL_RD;
			S_SHR_RD: state_d = (j_q <= idx_q) ? S_WRITE : S_SHR_WR;
			S_SHR_WR: state_d = S_SHR_RD;
			S_WRITE:  state_d = S_DONE;
			S_DONE:   if (!busy) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// memory port and result
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = {cur_len_q, cur_start_q};
		raddr = idx_q[AW-1:0];
		unique case (state_q)
			S_PREV_RD: raddr = AW'(idx_q - 1'b1);
			S_SHL_RD:  raddr = AW'(j_q + 1'b1);
			S_SHL_WR: begin
				we = 1'b1; waddr = j_q[AW-1:0]; wdata = rdata;
			end
			S_SHR_RD:  raddr = AW'(j_q - 1'b1);
			S_SHR_WR: begin
				we = 1'b1; waddr = j_q[AW-1:0]; wdata = rdata;
			end
			S_WRITE: begin
				we = 1'b1; wdata = {size_q, addr_q};
			end
			S_SCAN_CHK: begin
				if (type_q == REQ_ALLOC && rd_len > size_q) begin
					we = 1'b1; wdata = {rd_len - size_q, rd_start + size_q};
				end
			end
			S_FREE_DEC: begin
				if (prev_adj) begin
					we = 1'b1; waddr = AW'(idx_q - 1'b1);
					wdata = {rd_len + size_q + (next_adj ? cur_len_q : 32'd0),
						rd_start};
				end else if (next_adj) begin
					we = 1'b1; wdata = {cur_len_q + size_q, addr_q};
				end
			end
			default: ;
		endcase
		res.alloc_addr       = res_addr_q;
		res.status           = status_q;
		res.entries_used     = 9'(cnt_q);
		res.entries_peak     = 9'(peak_q);
		res.total_free_bytes = total_q;
		res.fail_count       = dcnt_q;
		res.lost_bytes       = dbytes_q;
		load = (state_q == S_DONE) && !busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			peak_q   <= '0;
			total_q  <= '0;
			dcnt_q   <= '0;
			dbytes_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_SCAN_CHK: if (type_q == REQ_ALLOC && rd_len >= size_q)
					total_q <= total_q - size_q;
				S_FREE_DEC: begin
					if (prev_adj || next_adj) total_q <= total_q + size_q;
					else if (cnt_q >= CW'(TABLE_DEPTH)) begin
						dcnt_q   <= dcnt_q + 32'd1;
						dbytes_q <= dbytes_q + size_q;
					end
				end
				S_SHL_RD: if (j_q + 1'b1 >= cnt_q) cnt_q <= cnt_q - 1'b1;
				S_WRITE: begin
					cnt_q   <= cnt_q + 1'b1;
					total_q <= total_q + size_q;
					if (peak_q < cnt_q + 1'b1) peak_q <= cnt_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				type_q     <= s_axis_tdata[0];
				addr_q     <= s_axis_tdata[32:1];
				size_q     <= in_size;
				idx_q      <= '0;
				res_addr_q <= '0;
				status_q   <= (s_axis_tdata[0] == REQ_ALLOC) ? ST_NOFIT : ST_OK;
			end
			S_SCAN_CHK: begin
				cur_start_q <= rd_start;
				cur_len_q   <= rd_len;
				if (type_q == REQ_ALLOC) begin
					if (rd_len >= size_q) begin
						res_addr_q <= rd_start;
						status_q   <= ST_OK;
						j_q        <= idx_q;
					end else idx_q <= idx_q + 1'b1;
				end else if (!(rd_start > addr_q)) idx_q <= idx_q + 1'b1;
			end
			S_PREV_RD: ;
			S_FREE_DEC: begin
				if (!prev_adj && !next_adj) begin
					j_q <= cnt_q;
					if (cnt_q >= CW'(TABLE_DEPTH)) status_q <= ST_FULL;
				end else begin
					j_q <= idx_q;
				end
			end
			S_SHL_WR: j_q <= j_q + 1'b1;
			S_SHR_WR: j_q <= j_q - 1'b1;
			default: ;
		endcase
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_DEPTH)) else $error("region count overflow");
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= cnt_q) else $error("peak below count");
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |-> (cnt_q < CW'(TABLE_DEPTH))) else $error("insert into full table");
	a_one_res: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> state_q == S_IDLE) else $error("result stage mismatch");
endmodule
